// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gpurs_pkg.sv =====
`timescale 1ns / 1ps

package gpurs_pkg;

    localparam int COORD_W = 10;
    localparam int SIZE_W  = 11;
    localparam int DELTA_W = 16;
    localparam int TOTAL_W = 32;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [TOTAL_W-1:0] t_word;

endpackage

// ===== rtl/core/grid_point_update_rect_sum.sv =====
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_op, i_row_lo, i_col_lo, i_row_hi, i_col_hi, i_delta
// result    out        o_valid / i_ready   o_total, o_range_error
// config    in         i_cfg_we            i_cfg_wdata (grid size)
//
// One item at a time. Each binary-search step over rows or columns is one pass through S_ROW or
// S_COL, and each touched tree cell adds an S_RMW step for its read from the single cell memory.
// An update is one walk, a query up to four. After reset the cell memory is swept to zero,
// one word per cycle, over all 2^(2*ceil(log2 MAX_SIZE)) words (1048576 at the default); no
// transfer is taken until it ends.
// A query result sits in an output register; the next item is taken while it waits.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module grid_point_update_rect_sum #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gpurs_pkg::SIZE_W-1:0]         i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_op,
    input  logic [gpurs_pkg::COORD_W-1:0]        i_row_lo,
    input  logic [gpurs_pkg::COORD_W-1:0]        i_col_lo,
    input  logic [gpurs_pkg::COORD_W-1:0]        i_row_hi,
    input  logic [gpurs_pkg::COORD_W-1:0]        i_col_hi,
    input  logic signed [gpurs_pkg::DELTA_W-1:0] i_delta,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [gpurs_pkg::TOTAL_W-1:0] o_total,
    output logic                                 o_range_error
);

    localparam int AW        = $clog2(MAX_SIZE);
    localparam int NW        = $clog2(MAX_SIZE + 1);
    localparam int CW        = (NW > gpurs_pkg::SIZE_W) ? NW : gpurs_pkg::SIZE_W;
    localparam int MEM_DEPTH = 1 << (2 * AW);
    localparam int GRID_RST  = (1024 > MAX_SIZE) ? MAX_SIZE : 1024;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ROW   = 3'd2;
    localparam logic [2:0] S_COL   = 3'd3;
    localparam logic [2:0] S_RMW   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                       r_state;
    logic [2*AW-1:0]                  r_clr_addr;
    logic [NW-1:0]                    r_grid;
    logic                             r_is_query;
    logic                             r_qerr;
    gpurs_pkg::t_size                 r_row_a;
    gpurs_pkg::t_size                 r_row_b;
    gpurs_pkg::t_size                 r_col_a;
    gpurs_pkg::t_size                 r_col_b;
    logic [gpurs_pkg::DELTA_W-1:0]    r_delta;
    logic [1:0]                       r_term;
    logic                             r_row_ok;
    logic                             r_col_ok;
    logic [NW-1:0]                    r_rlo;
    logic [NW-1:0]                    r_rend;
    logic [NW-1:0]                    r_clo;
    logic [NW-1:0]                    r_cend;
    logic [AW-1:0]                    r_row_mid;
    logic [2*AW-1:0]                  r_addr;
    gpurs_pkg::t_word                 r_rdata;
    gpurs_pkg::t_word                 r_acc;
    logic                             r_out_valid;
    gpurs_pkg::t_word                 r_total;
    logic                             r_err;

    gpurs_pkg::t_word                 mem [0:MEM_DEPTH-1];

    logic [NW:0]                      row_sum;
    logic [NW:0]                      col_sum;
    logic [NW-1:0]                    row_mid;
    logic [NW-1:0]                    col_mid;
    logic [CW-1:0]                    cur_row;
    logic [CW-1:0]                    cur_col;
    logic                             row_hit;
    logic                             col_hit;
    logic                             row_right;
    logic                             col_right;
    logic                             term_more;
    logic [1:0]                       next_term;
    logic [2*AW-1:0]                  rd_addr;
    logic                             mem_we;
    logic [2*AW-1:0]                  mem_waddr;
    gpurs_pkg::t_word                 mem_wdata;
    logic                             take;
    logic                             out_load;
    logic                             q_bad;
    gpurs_pkg::t_size                 rh_inc;
    gpurs_pkg::t_size                 ch_inc;

    assign take     = i_valid && o_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // Midpoint of the live range [lo, end-1], rounded down as the search expects.
    assign row_sum = {1'b0, r_rlo} + {1'b0, r_rend} - (NW+1)'(1);
    assign col_sum = {1'b0, r_clo} + {1'b0, r_cend} - (NW+1)'(1);
    assign row_mid = row_sum[NW:1];
    assign col_mid = col_sum[NW:1];

    // Query terms: bit 0 selects row_hi+1, bit 1 selects col_hi+1.
    assign cur_row = r_term[0] ? CW'(r_row_b) : CW'(r_row_a);
    assign cur_col = r_term[1] ? CW'(r_col_b) : CW'(r_col_a);

    assign row_hit = r_is_query ? (cur_row <= CW'(row_mid)) : (cur_row >= CW'(row_mid));
    assign col_hit = r_is_query ? (cur_col <= CW'(col_mid)) : (cur_col >= CW'(col_mid));

    // A suffix walk moves left on a hit; an update walk moves right on a hit.
    assign row_right = row_hit ^ r_is_query;
    assign col_right = col_hit ^ r_is_query;

    assign rd_addr = {r_row_mid, col_mid[AW-1:0]};

    assign rh_inc = gpurs_pkg::SIZE_W'(i_row_hi) + gpurs_pkg::SIZE_W'(1);
    assign ch_inc = gpurs_pkg::SIZE_W'(i_col_hi) + gpurs_pkg::SIZE_W'(1);
    assign q_bad  = (i_row_lo > i_row_hi) || (i_col_lo > i_col_hi)
                 || (CW'(i_row_hi) >= CW'(r_grid)) || (CW'(i_col_hi) >= CW'(r_grid));

    always_comb begin
        term_more = 1'b0;
        next_term = r_term;
        case (r_term)
            2'd0: begin
                if (r_row_ok) begin
                    term_more = 1'b1;
                    next_term = 2'd1;
                end else if (r_col_ok) begin
                    term_more = 1'b1;
                    next_term = 2'd2;
                end
            end
            2'd1: begin
                if (r_col_ok) begin
                    term_more = 1'b1;
                    next_term = 2'd2;
                end
            end
            2'd2: begin
                if (r_row_ok) begin
                    term_more = 1'b1;
                    next_term = 2'd3;
                end
            end
            default: begin
                term_more = 1'b0;
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rdata + {{(gpurs_pkg::TOTAL_W-gpurs_pkg::DELTA_W){r_delta[gpurs_pkg::DELTA_W-1]}},
                               r_delta};
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == S_RMW && !r_is_query) begin
            mem_we = 1'b1;
        end
    end

    // Cell memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_grid      <= NW'(GRID_RST);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (32'(i_cfg_wdata) > 32'(MAX_SIZE)) begin
                    r_grid <= NW'(MAX_SIZE);
                end else begin
                    r_grid <= NW'(i_cfg_wdata);
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + (2*AW)'(1);
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take) begin
                        r_state <= S_ROW;
                        if (i_op == gpurs_pkg::OP_QUERY && q_bad) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_ROW: begin
                    if (r_rlo < r_rend) begin
                        if (row_hit) begin
                            r_state <= S_COL;
                        end
                    end else if (r_is_query && term_more) begin
                        r_state <= S_ROW;
                    end else if (r_is_query) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_COL: begin
                    if (r_clo < r_cend) begin
                        if (col_hit) begin
                            r_state <= S_RMW;
                        end
                    end else begin
                        r_state <= S_ROW;
                    end
                end
                S_RMW: begin
                    r_state <= S_COL;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Walk bounds, item fields and the running sum.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    r_is_query <= (i_op == gpurs_pkg::OP_QUERY);
                    r_qerr     <= (i_op == gpurs_pkg::OP_QUERY) && q_bad;
                    r_row_a    <= gpurs_pkg::SIZE_W'(i_row_lo);
                    r_col_a    <= gpurs_pkg::SIZE_W'(i_col_lo);
                    r_row_b    <= rh_inc;
                    r_col_b    <= ch_inc;
                    r_row_ok   <= CW'(rh_inc) < CW'(r_grid);
                    r_col_ok   <= CW'(ch_inc) < CW'(r_grid);
                    r_delta    <= i_delta;
                    r_term     <= 2'd0;
                    r_acc      <= '0;
                    r_rlo      <= '0;
                    r_rend     <= r_grid;
                end
            end
            S_ROW: begin
                if (r_rlo < r_rend) begin
                    if (row_right) begin
                        r_rlo <= row_mid + NW'(1);
                    end else begin
                        r_rend <= row_mid;
                    end
                    if (row_hit) begin
                        r_row_mid <= row_mid[AW-1:0];
                        r_clo     <= '0;
                        r_cend    <= r_grid;
                    end
                end else if (r_is_query && term_more) begin
                    r_term <= next_term;
                    r_rlo  <= '0;
                    r_rend <= r_grid;
                end
            end
            S_COL: begin
                if (r_clo < r_cend) begin
                    if (col_right) begin
                        r_clo <= col_mid + NW'(1);
                    end else begin
                        r_cend <= col_mid;
                    end
                    if (col_hit) begin
                        r_addr <= rd_addr;
                    end
                end
            end
            S_RMW: begin
                // The two mixed terms of the inclusion-exclusion are subtracted.
                if (r_is_query) begin
                    if (r_term[0] ^ r_term[1]) begin
                        r_acc <= r_acc - r_rdata;
                    end else begin
                        r_acc <= r_acc + r_rdata;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_total <= r_acc;
            r_err   <= r_qerr;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_total       = r_total;
    assign o_range_error = r_err;

    `ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && o_range_error, o_total == '0, "error result with nonzero total")
    `ASSERT_NOW(a_row_bounds, i_clk, i_rst_n, r_state == S_ROW || r_state == S_COL, r_rlo <= r_rend, "row search range inverted")
    `ASSERT_NEXT(a_load_src, i_clk, i_rst_n, !o_valid, !o_valid || $past(r_state) == S_DONE, "result appeared outside completion")
    `ASSERT_NOW(a_rmw_from_col, i_clk, i_rst_n, r_state == S_RMW, $past(r_state) == S_COL, "cell access without a column hit")

endmodule
